// ----- sv/bse_pkg.sv -----
`timescale 1ns / 1ps

package bse_pkg;

  localparam int unsigned MAX_CURVE_POINTS = 8;

  localparam int unsigned MV_W     = 16;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned PIDX_W   = 3;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam int unsigned DIV_NUM_W = 24;
  localparam int unsigned DIV_DEN_W = 17;
  localparam int unsigned DIV_CNT_W = 5;

  // divide by 100 as multiply by ceil(2^30 / 100) and shift by 30
  localparam int unsigned FILT_RECIP_W = 24;
  localparam int unsigned FILT_PROD_W  = 48;
  localparam int unsigned FILT_SHIFT   = 30;
  localparam logic [FILT_RECIP_W-1:0] FILT_RECIP = 24'd10737419;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PACK_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PACK_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd6;

  typedef struct packed {
    logic signed [15:0] adc_count;
    logic               adc_present;
  } in_t;

  typedef struct packed {
    logic [MV_W-1:0]  raw_mv;
    logic [MV_W-1:0]  filtered_mv;
    logic [PCT_W-1:0] charge_percent;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW,
    ST_FILT,
    ST_FDIV,
    ST_SEL,
    ST_LDIV,
    ST_P0,
    ST_PN,
    ST_WALK0,
    ST_WALK,
    ST_M1,
    ST_M2,
    ST_CSTART,
    ST_CDIV,
    ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RAW,
    OP_SEED,
    OP_FSTART,
    OP_FSTORE,
    OP_LSTART,
    OP_PCT_ZERO,
    OP_PCT_FULL,
    OP_PCT_CHG,
    OP_PCT_LQ,
    OP_PCT_CQ,
    OP_REWIND,
    OP_SET_LAST,
    OP_WALK_INIT,
    OP_WALK_STEP,
    OP_SEG_SAVE,
    OP_MUL1,
    OP_MUL2,
    OP_CSTART,
    OP_EMIT
  } op_e;

  typedef struct packed {
    logic seed;
    logic linear;
    logic lin_lo;
    logic lin_hi;
    logic p0_hit;
    logic pn_hit;
    logic seg_hit;
    logic span_zero;
    logic last_pt;
  } status_t;

endpackage

// ----- sv/bse_if.sv -----
`timescale 1ns / 1ps

interface bse_in_if import bse_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bse_out_if import bse_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/battery_soc_estimator.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// in_i      in   valid/ready          adc_count, adc_present
// out_o     out  valid/ready          raw_mv, filtered_mv, charge_percent
// cfg       in   cfg_we_i, no stall   cfg_idx_i, cfg_data_i
//
// one item at a time, each through the 24-step divider (at most once, for the
// linear map or the interpolation) and the curve walk of one segment per cycle;
// the filter divides by 100 with a reciprocal multiply. the next input is taken
// the cycle after the result is loaded. reset empties the filter state and
// loads the register defaults. a held result in the output register does not
// block the next input; a new result waits in its final state until the output
// register frees.

module battery_soc_estimator import bse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bse_in_if.sink                in_i,
  bse_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  op_e                  op;
  status_t              status;
  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;

  bse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .div_done_i  (div_done),
    .op_o        (op)
  );

  bse_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .op_i        (op),
    .status_o    (status),
    .div_start_o (div_start),
    .div_num_o   (div_num),
    .div_den_o   (div_den),
    .div_quo_i   (div_quo),
    .out_data_o  (out_o.data)
  );

  bse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while an item is in flight");

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_div_done_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> !in_i.ready)
    else $error("divider finished with no item in flight");

endmodule

// ----- sv/bse_div.sv -----
`timescale 1ns / 1ps

module bse_div import bse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W:0]   trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, quo_q[DIV_NUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DIV_DEN_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIV_DEN_W-1:0];
        quo_d = {quo_q[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- sv/bse_ctrl.sv -----
`timescale 1ns / 1ps

module bse_ctrl import bse_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  input  logic    div_done_i,
  output op_e     op_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   emit;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    emit    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = ST_RAW;
        end
      end
      ST_RAW: begin
        op_o    = OP_RAW;
        state_d = ST_FILT;
      end
      ST_FILT: begin
        if (status_i.seed) begin
          op_o    = OP_SEED;
          state_d = ST_SEL;
        end else begin
          op_o    = OP_FSTART;
          state_d = ST_FDIV;
        end
      end
      ST_FDIV: begin
        op_o    = OP_FSTORE;
        state_d = ST_SEL;
      end
      ST_SEL: begin
        priority if (!status_i.linear) begin
          op_o    = OP_REWIND;
          state_d = ST_P0;
        end else if (status_i.lin_lo) begin
          op_o    = OP_PCT_ZERO;
          state_d = ST_DONE;
        end else if (status_i.lin_hi) begin
          op_o    = OP_PCT_FULL;
          state_d = ST_DONE;
        end else begin
          op_o    = OP_LSTART;
          state_d = ST_LDIV;
        end
      end
      ST_LDIV: begin
        if (div_done_i) begin
          op_o    = OP_PCT_LQ;
          state_d = ST_DONE;
        end
      end
      ST_P0: begin
        if (status_i.p0_hit) begin
          op_o    = OP_PCT_CHG;
          state_d = ST_DONE;
        end else begin
          op_o    = OP_SET_LAST;
          state_d = ST_PN;
        end
      end
      ST_PN: begin
        if (status_i.pn_hit) begin
          op_o    = OP_PCT_CHG;
          state_d = ST_DONE;
        end else begin
          op_o    = OP_REWIND;
          state_d = ST_WALK0;
        end
      end
      ST_WALK0: begin
        op_o    = OP_WALK_INIT;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        priority if (status_i.seg_hit && status_i.span_zero) begin
          op_o    = OP_PCT_CHG;
          state_d = ST_DONE;
        end else if (status_i.seg_hit) begin
          op_o    = OP_SEG_SAVE;
          state_d = ST_M1;
        end else if (status_i.last_pt) begin
          // no segment holds the voltage
          op_o    = OP_PCT_ZERO;
          state_d = ST_DONE;
        end else begin
          op_o    = OP_WALK_STEP;
        end
      end
      ST_M1: begin
        op_o    = OP_MUL1;
        state_d = ST_M2;
      end
      ST_M2: begin
        op_o    = OP_MUL2;
        state_d = ST_CSTART;
      end
      ST_CSTART: begin
        op_o    = OP_CSTART;
        state_d = ST_CDIV;
      end
      ST_CDIV: begin
        if (div_done_i) begin
          op_o    = OP_PCT_CQ;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          op_o    = OP_EMIT;
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = emit | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/bse_dp.sv -----
`timescale 1ns / 1ps

module bse_dp import bse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_t                   in_data_i,
  input  op_e                   op_i,
  output status_t               status_o,
  output logic                  div_start_o,
  output logic [DIV_NUM_W-1:0]  div_num_o,
  output logic [DIV_DEN_W-1:0]  div_den_o,
  input  logic [DIV_NUM_W-1:0]  div_quo_i,
  output out_t                  out_data_o
);

  // configuration
  logic [CNT_W-1:0]  pcnt_q;
  logic [63:0]       vlo_q;
  logic [63:0]       vhi_q;
  logic [55:0]       chg_q;
  logic [MV_W-1:0]   pmin_q;
  logic [MV_W-1:0]   pmax_q;
  logic [MV_W-1:0]   gain_q;

  // per item
  logic [30:0]       prod_q;
  logic [MV_W-1:0]   raw_q;
  logic [MV_W-1:0]   sm_q;
  logic [DIV_NUM_W-1:0] filt_q;
  logic [PCT_W-1:0]  pct_q;
  logic [PIDX_W-1:0] pidx_q;
  logic [MV_W-1:0]   vl_q;
  logic [PCT_W-1:0]  cl_q;
  logic [PCT_W-1:0]  cr_q;
  logic [MV_W-1:0]   span_q;
  logic [MV_W-1:0]   d_q;
  logic [22:0]       acc_q;
  out_t              out_q;

  logic [CNT_W-1:0]  n_eff;
  logic [PIDX_W-1:0] last_idx;
  logic [MV_W-1:0]   pv;
  logic [PCT_W-1:0]  pc;
  logic [MV_W-1:0]   raw_sat;
  logic [19:0]       prod_sh;
  logic [DIV_NUM_W-1:0] filt_num;
  logic [FILT_PROD_W-1:0] filt_prod;
  logic [MV_W-1:0]   filt_quo;
  logic [DIV_NUM_W-1:0] lin_num;
  logic [DIV_NUM_W-1:0] curve_num;
  logic [MV_W-1:0]   v_off;
  logic [MV_W-1:0]   seg_span;
  logic [PCT_W-1:0]  curve_sat;

  always_comb begin
    n_eff    = (pcnt_q > CNT_W'(MAX_CURVE_POINTS)) ? CNT_W'(MAX_CURVE_POINTS) : pcnt_q;
    last_idx = PIDX_W'(n_eff - 1'b1);
    pv       = pidx_q[2] ? vhi_q[pidx_q[1:0]*MV_W +: MV_W] : vlo_q[pidx_q[1:0]*MV_W +: MV_W];
    pc       = chg_q[pidx_q*PCT_W +: PCT_W];

    prod_sh  = prod_q[30:11];
    raw_sat  = (|prod_sh[19:16]) ? '1 : prod_sh[15:0];

    filt_num = 24'({8'b0, raw_q} * 24'd35) + 24'({8'b0, sm_q} * 24'd65) + 24'd50;
    // numerator stays below 2^23, so the reciprocal gives the exact quotient
    filt_prod = FILT_PROD_W'(filt_q) * FILT_PROD_W'(FILT_RECIP);
    filt_quo  = filt_prod[FILT_SHIFT +: MV_W];
    v_off    = sm_q - pmin_q;
    lin_num  = 24'({8'b0, v_off} * 24'd100);
    curve_num = {acc_q, 1'b0} + {8'b0, span_q};
    seg_span = pv - vl_q;
    curve_sat = (div_quo_i > DIV_NUM_W'(PCT_FULL)) ? PCT_FULL : div_quo_i[PCT_W-1:0];

    status_o.seed      = (sm_q == '0);
    status_o.linear    = (n_eff < CNT_W'(2));
    status_o.lin_lo    = (sm_q <= pmin_q);
    status_o.lin_hi    = (sm_q >= pmax_q);
    status_o.p0_hit    = (sm_q <= pv);
    status_o.pn_hit    = (sm_q >= pv);
    status_o.seg_hit   = (sm_q >= vl_q) && (sm_q <= pv);
    status_o.span_zero = (seg_span == '0);
    status_o.last_pt   = (pidx_q == last_idx);

    div_start_o = (op_i == OP_LSTART) || (op_i == OP_CSTART);
    unique case (op_i)
      OP_LSTART: begin
        div_num_o = lin_num;
        div_den_o = {1'b0, pmax_q - pmin_q};
      end
      default: begin
        div_num_o = curve_num;
        div_den_o = {span_q, 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= '0;
      vlo_q  <= '0;
      vhi_q  <= '0;
      chg_q  <= '0;
      pmin_q <= '0;
      pmax_q <= 16'hFFFF;
      gain_q <= 16'd256;
      sm_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POINT_COUNT: pcnt_q <= cfg_data_i[CNT_W-1:0];
          CFG_VOLT_LOW:    vlo_q  <= cfg_data_i;
          CFG_VOLT_HIGH:   vhi_q  <= cfg_data_i;
          CFG_CHARGE:      chg_q  <= cfg_data_i[55:0];
          CFG_PACK_MIN:    pmin_q <= cfg_data_i[MV_W-1:0];
          CFG_PACK_MAX:    pmax_q <= cfg_data_i[MV_W-1:0];
          CFG_GAIN:        gain_q <= cfg_data_i[MV_W-1:0];
          default: ;
        endcase
      end
      if (op_i == OP_SEED) begin
        sm_q <= raw_q;
      end else if (op_i == OP_FSTORE) begin
        sm_q <= filt_quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: begin
        // negative counts and an absent converter both give zero
        if (in_data_i.adc_present && !in_data_i.adc_count[15]) begin
          prod_q <= 31'(in_data_i.adc_count[14:0] * gain_q);
        end else begin
          prod_q <= '0;
        end
      end
      OP_RAW:       raw_q  <= raw_sat;
      OP_FSTART:    filt_q <= filt_num;
      OP_PCT_ZERO:  pct_q  <= '0;
      OP_PCT_FULL:  pct_q  <= PCT_FULL;
      OP_PCT_CHG:   pct_q  <= pc;
      OP_PCT_LQ:    pct_q  <= div_quo_i[PCT_W-1:0];
      OP_PCT_CQ:    pct_q  <= curve_sat;
      OP_REWIND:    pidx_q <= '0;
      OP_SET_LAST:  pidx_q <= last_idx;
      OP_WALK_INIT, OP_WALK_STEP: begin
        vl_q   <= pv;
        cl_q   <= pc;
        pidx_q <= pidx_q + 1'b1;
      end
      OP_SEG_SAVE: begin
        span_q <= seg_span;
        d_q    <= sm_q - vl_q;
        cr_q   <= pc;
      end
      OP_MUL1:      acc_q  <= 23'(cl_q * (span_q - d_q));
      OP_MUL2:      acc_q  <= acc_q + 23'(cr_q * d_q);
      OP_EMIT: begin
        out_q.raw_mv         <= raw_q;
        out_q.filtered_mv    <= sm_q;
        out_q.charge_percent <= pct_q;
      end
      default: ;
    endcase
  end

  assign out_data_o = out_q;

endmodule
